[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tone generator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSTG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LSTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/lstg_pkg.sv]
// ----------------------------------------------------------------------------
// lstg_pkg
// Types, constants and the arctangent table of the sine tone generator.
// ----------------------------------------------------------------------------
package lstg_pkg;

  // Field and register widths
  localparam int RATE_W     = 19;
  localparam int FREQ_W     = 19;
  localparam int CNT_W      = 4;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int CH_OUT_W   = 3;
  localparam int SAMPLE_W   = 16;

  // Channel limit
  localparam int MAX_CHANNELS = 8;
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // CORDIC row
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN          = 24;
  localparam int CORDIC_STAGES     =
    (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
  localparam int SHIFT_W   = 5;
  localparam int CW        = 34;
  localparam int ANGLE_W   = 32;
  localparam int FRAC_BITS = 30;
  localparam int AMP       = 32767;
  localparam int PROD_W    = CW + SAMPLE_W;
  localparam int ROUND_BIAS = (1 << FRAC_BITS) - 1;
  localparam logic [CW-1:0] CORDIC_ONE = CW'(652032874);

  // Divider
  localparam int REM_W     = RATE_W;
  localparam int DIV_CNT_W = 6;

  // Reset values
  localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(48000);
  localparam logic [FREQ_W-1:0] FREQ_RESET   = FREQ_W'(1000);
  localparam logic [CNT_W-1:0]  CNT_RESET    = CNT_W'(2);
  localparam logic [RATE_W-1:0] PERIOD_RESET = RATE_W'(48000 / 1000);

  // Channel modes
  localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE   = 3'd0,
    REG_TONE_FREQ     = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_CHANNEL_MODE  = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic                 start;
    logic [REM_W-1:0]     rem_init;
    logic [ANGLE_W-1:0]   num;
    logic [REM_W-1:0]     den;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ANGLE_W-1:0] quot;
  } div_rsp_t;

  // atan(2^-k) as a fraction of a full turn, scaled by 2^32
  function automatic logic [CW-1:0] atan_turn(input logic [SHIFT_W-1:0] k);
    logic [CW-1:0] t;
    unique case (k)
      5'd0:    t = CW'(536870912);
      5'd1:    t = CW'(316933406);
      5'd2:    t = CW'(167458907);
      5'd3:    t = CW'(85004756);
      5'd4:    t = CW'(42667331);
      5'd5:    t = CW'(21354465);
      5'd6:    t = CW'(10679838);
      5'd7:    t = CW'(5340245);
      5'd8:    t = CW'(2670163);
      5'd9:    t = CW'(1335087);
      5'd10:   t = CW'(667544);
      5'd11:   t = CW'(333772);
      5'd12:   t = CW'(166886);
      5'd13:   t = CW'(83443);
      5'd14:   t = CW'(41722);
      5'd15:   t = CW'(20861);
      5'd16:   t = CW'(10430);
      5'd17:   t = CW'(5215);
      5'd18:   t = CW'(2608);
      5'd19:   t = CW'(1304);
      5'd20:   t = CW'(652);
      5'd21:   t = CW'(326);
      5'd22:   t = CW'(163);
      5'd23:   t = CW'(81);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

[rtl/lstg_div.sv]
// ----------------------------------------------------------------------------
// lstg_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lstg_div import lstg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [REM_W-1:0]     rem_q, den_q, rem_d;
  logic [ANGLE_W-1:0]   num_q, quot_q;
  logic [REM_W:0]       trial, diff;
  logic                 ge;

  assign trial = {rem_q, num_q[ANGLE_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign rem_d = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Pulse done for one cycle after the final step
      done_q <= !req_i.start && busy_q && (cnt_q == DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: shift the numerator in, one bit per step
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      num_q  <= {num_q[ANGLE_W-2:0], 1'b0};
      quot_q <= {quot_q[ANGLE_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[rtl/lstg_cordic_cell.sv]
// ----------------------------------------------------------------------------
// lstg_cordic_cell
// One CORDIC rotation step, registered, handing its vector to the next cell.
// ----------------------------------------------------------------------------
module lstg_cordic_cell import lstg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cordic_t            data_i,
  input  logic [SHIFT_W-1:0] shift_i,
  input  logic [CW-1:0]      atan_i,
  output logic               valid_o,
  output cordic_t            data_o
);

  logic                 valid_q;
  cordic_t              data_q, data_d;
  logic signed [CW-1:0] xs, ys, at;

  assign xs = data_i.x >>> shift_i;
  assign ys = data_i.y >>> shift_i;
  assign at = atan_i;

  // Rotate toward zero residual angle
  always_comb begin
    if (!data_i.z[CW-1]) begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - at;
    end else begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/looping_sine_tone_generator_unit.sv]
// ----------------------------------------------------------------------------
// looping_sine_tone_generator_unit
// Looping sine tone source: one interleaved audio frame per input request.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes sample rate, tone frequency, channel count and channel mode; it is
//   taken only while no frame is in flight. Any known register write resets
//   the phase; an unknown index is dropped. Writing the rate or frequency
//   starts a 19-step period division; both request channels stall until that
//   division has written the new period back.
//   Input channel (in_valid_i/in_ready_o, restart_i): each request makes one
//   frame. The phase angle comes from a 32-step bit-serial divider, then the
//   vector runs through a row of CORDIC_ITERATIONS rotation cells and a
//   two-stage scaler. The channels of a frame then follow one per cycle
//   while the receiver is ready. One frame at a time.
//   Output channel (out_valid_o/out_ready_i, channel_o, sample_o, last_o)
//   holds each sample in an output register; a stalled receiver freezes the
//   frame, and the next request is taken while the final sample still waits.
//   Reset restores the register defaults (48 kHz, 1 kHz, two channels, both
//   on), a period of 48 samples and phase zero, with no clearing pass.
// ----------------------------------------------------------------------------
module looping_sine_tone_generator_unit import lstg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CH_OUT_W-1:0]   channel_o,
  output logic [SAMPLE_W-1:0]   sample_o,
  output logic                  last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLOAD,
    ST_PDIV,
    ST_ADIV,
    ST_CORDIC,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Configuration and phase state
  logic [RATE_W-1:0] rate_q, period_q, phase_q;
  logic [FREQ_W-1:0] freq_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [MODE_W-1:0] mode_q;

  // Output register
  logic                out_vld_q, last_q;
  logic [CH_OUT_W-1:0] chan_q;
  logic [SAMPLE_W-1:0] out_smp_q;
  logic [CH_W-1:0]     ch_q, last_ch;

  logic in_fire, cfg_fire;
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Phase for this frame and the one after it
  logic [RATE_W-1:0] phase_use, phase_next;
  logic [RATE_W:0]   phase_inc;
  assign phase_use  = (restart_i || (phase_q >= period_q)) ? '0 : phase_q;
  assign phase_inc  = {1'b0, phase_use} + 1'b1;
  assign phase_next = (phase_inc >= {1'b0, period_q}) ? '0 : phase_inc[RATE_W-1:0];

  // Shared divider: period = rate / freq, then angle = phase * 2^32 / period
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req.start = in_fire || (state_q == ST_PLOAD);
    if (state_q == ST_PLOAD) begin
      div_req.rem_init = '0;
      div_req.num      = {rate_q, (ANGLE_W - RATE_W)'(0)};
      div_req.den      = (freq_q == '0) ? REM_W'(1) : freq_q;
      div_req.steps    = DIV_CNT_W'(RATE_W);
    end else begin
      div_req.rem_init = phase_use;
      div_req.num      = '0;
      div_req.den      = period_q;
      div_req.steps    = DIV_CNT_W'(ANGLE_W);
    end
  end

  lstg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Fold the second and third quadrants onto the first and fourth
  logic [ANGLE_W-1:0] angle, angle_f;
  assign angle   = div_rsp.quot;
  assign angle_f = (angle[ANGLE_W-1] ^ angle[ANGLE_W-2])
                   ? (ANGLE_W'(1) << (ANGLE_W - 1)) - angle : angle;

  // CORDIC row
  cordic_t stg_data [CORDIC_STAGES+1];
  logic    stg_vld  [CORDIC_STAGES+1];

  assign stg_vld[0]    = (state_q == ST_ADIV) && div_rsp.done;
  assign stg_data[0].x = CORDIC_ONE;
  assign stg_data[0].y = '0;
  assign stg_data[0].z = {{(CW - ANGLE_W){angle_f[ANGLE_W-1]}}, angle_f};

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    lstg_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_vld[g]),
      .data_i  (stg_data[g]),
      .shift_i (SHIFT_W'(g)),
      .atan_i  (atan_turn(SHIFT_W'(g))),
      .valid_o (stg_vld[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  // Scale by 32767, divide by 2^30 toward zero, saturate
  logic                       prod_vld_q, smp_vld_q;
  logic signed [PROD_W-1:0]   prod_d, prod_q, adj, quo;
  logic signed [CW-1:0]       y_fin;
  logic        [SAMPLE_W-1:0] smp_d, smp_q;

  assign y_fin  = stg_data[CORDIC_STAGES].y;
  assign prod_d = PROD_W'(y_fin) * PROD_W'(AMP);
  assign adj    = prod_q + (prod_q[PROD_W-1] ? PROD_W'(ROUND_BIAS) : PROD_W'(0));
  assign quo    = adj >>> FRAC_BITS;

  always_comb begin
    if (quo > PROD_W'(AMP)) begin
      smp_d = SAMPLE_W'(AMP);
    end else if (quo < PROD_W'(-AMP)) begin
      smp_d = SAMPLE_W'(-AMP);
    end else begin
      smp_d = quo[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      smp_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= stg_vld[CORDIC_STAGES];
      smp_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_vld[CORDIC_STAGES]) begin
      prod_q <= prod_d;
    end
    if (prod_vld_q) begin
      smp_q <= smp_d;
    end
  end

  // Frame layout
  logic left_on, right_on, carries;
  assign left_on  = (mode_q == MODE_LEFT) || (mode_q == MODE_BOTH);
  assign right_on = (mode_q == MODE_RIGHT) || (mode_q == MODE_BOTH);
  assign carries  = ((ch_q == CH_W'(0)) && left_on) || ((ch_q == CH_W'(1)) && right_on);

  always_comb begin
    if (cnt_q == '0) begin
      last_ch = '0;
    end else if (int'(cnt_q) > MAX_CHANNELS) begin
      last_ch = CH_W'(MAX_CHANNELS - 1);
    end else begin
      last_ch = CH_W'(cnt_q - 1'b1);
    end
  end

  // Sequencer, configuration registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rate_q    <= RATE_RESET;
      freq_q    <= FREQ_RESET;
      cnt_q     <= CNT_RESET;
      mode_q    <= MODE_BOTH;
      period_q  <= PERIOD_RESET;
      phase_q   <= '0;
      ch_q      <= '0;
      out_vld_q <= 1'b0;
      chan_q    <= '0;
      out_smp_q <= '0;
      last_q    <= 1'b0;
    end else begin
      // Drop a taken sample; while emitting, the emit branch owns the register
      if (out_ready_i && (state_q != ST_EMIT)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_fire) begin
            unique case (cfg_reg_e'(cfg_index_i))
              REG_SAMPLE_RATE: begin
                rate_q  <= cfg_data_i[RATE_W-1:0];
                phase_q <= '0;
                state_q <= ST_PLOAD;
              end
              REG_TONE_FREQ: begin
                freq_q  <= cfg_data_i[FREQ_W-1:0];
                phase_q <= '0;
                state_q <= ST_PLOAD;
              end
              REG_CHANNEL_COUNT: begin
                cnt_q   <= cfg_data_i[CNT_W-1:0];
                phase_q <= '0;
              end
              REG_CHANNEL_MODE: begin
                mode_q  <= cfg_data_i[MODE_W-1:0];
                phase_q <= '0;
              end
              default: begin
              end
            endcase
          end else if (in_fire) begin
            phase_q <= phase_next;
            state_q <= ST_ADIV;
          end
        end
        ST_PLOAD: begin
          state_q <= ST_PDIV;
        end
        ST_PDIV: begin
          if (div_rsp.done) begin
            // Zero quotient means a one-sample period
            period_q <= (div_rsp.quot[RATE_W-1:0] == '0) ? RATE_W'(1)
                                                         : div_rsp.quot[RATE_W-1:0];
            state_q  <= ST_IDLE;
          end
        end
        ST_ADIV: begin
          if (div_rsp.done) begin
            state_q <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (smp_vld_q) begin
            ch_q    <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Advance one channel whenever the output register is free
          if (!out_vld_q || out_ready_i) begin
            out_vld_q <= 1'b1;
            chan_q    <= CH_OUT_W'(ch_q);
            out_smp_q <= carries ? smp_q : '0;
            last_q    <= (ch_q == last_ch);
            if (ch_q == last_ch) begin
              state_q <= ST_IDLE;
            end else begin
              ch_q <= ch_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign channel_o   = chan_q;
  assign sample_o    = out_smp_q;
  assign last_o      = last_q;

endmodule

[rtl/lstg_checker.sv]
// ----------------------------------------------------------------------------
// lstg_checker
// Port-level checks for the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lstg_checker import lstg_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_ready_o,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [CH_OUT_W-1:0]   channel_o,
  input logic [SAMPLE_W-1:0]   sample_o,
  input logic                  last_o
);

  // A stalled sample holds
  `LSTG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(sample_o) && $stable(channel_o) && $stable(last_o))

  // Channels beyond the stereo pair stay silent
  `LSTG_ASSERT_IMPL(a_high_ch_silent, clk_i, rst_ni, out_valid_o && (channel_o > CH_OUT_W'(1)), sample_o == '0)

  // A new request is taken only once the frame is fully queued
  `LSTG_ASSERT_IMPL(a_idle_after_last, clk_i, rst_ni, in_ready_o, !out_valid_o || last_o)

  // Ready for a request implies ready for a write
  `LSTG_ASSERT_IMPL(a_in_implies_cfg, clk_i, rst_ni, in_ready_o, cfg_ready_o)

  // One frame in flight at a time
  `LSTG_ASSERT_NEXT(a_one_frame, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind looping_sine_tone_generator_unit lstg_checker u_lstg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .channel_o   (channel_o),
  .sample_o    (sample_o),
  .last_o      (last_o)
);
